>>> src/mbp_pkg.sv
// Shared types, constants and fixed-point helpers of the perceptron training unit.
`timescale 1ns / 1ps
package mbp_pkg;

    localparam int INPUT_COUNT   = 2;
    localparam int HIDDEN_COUNT  = 4;
    localparam int OUTPUT_COUNT  = 2;
    localparam int WEIGHT_BITS   = 16;
    localparam int FRACTION_BITS = 12;

    localparam int HID_IDX_BITS  = $clog2(HIDDEN_COUNT);
    localparam int OUT_IDX_BITS  = $clog2(OUTPUT_COUNT);
    localparam int HW_COUNT      = HIDDEN_COUNT * INPUT_COUNT;

    localparam int ACT_BITS      = FRACTION_BITS + 1;   // sigmoid value 0..ONE
    localparam int ERR_BITS      = FRACTION_BITS + 2;   // output error, signed
    localparam int NET_BITS      = 22;                  // neuron net before sigmoid
    localparam int MA_BITS       = 22;                  // shared multiplier, first operand
    localparam int MB_BITS       = 20;                  // shared multiplier, second operand
    localparam int ACC_BITS      = 44;
    localparam int SLOPE_BITS    = FRACTION_BITS - 1;
    localparam int LR_BITS       = 13;
    localparam int THR_BITS      = 16;
    localparam int EH_BITS       = 20;
    localparam int UPD_BITS      = 22;

    localparam int ONE_VAL       = 1 << FRACTION_BITS;
    localparam int SIG_SAT       = 5 * ONE_VAL;
    localparam int SIG_KNEE2     = (19 * ONE_VAL) / 8;
    localparam int SIG_OFS2      = (27 * ONE_VAL) / 32;
    localparam int SIG_OFS1      = (5 * ONE_VAL) / 8;
    localparam int SIG_OFS0      = ONE_VAL / 2;
    localparam int LR_RESET      = 3277;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_INFER = 2'd1,
        CMD_TRAIN = 2'd2,
        CMD_NOP   = 2'd3
    } mbp_cmd_t;

    typedef enum logic [1:0] {
        REG_LEARNING_RATE = 2'd0,
        REG_THRESHOLD     = 2'd1
    } mbp_reg_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_HID, S_OMAC, S_OSIG, S_EMAC, S_EH,
        S_HD, S_HL, S_HT, S_HW, S_OD, S_OL, S_OT, S_OU, S_ON, S_OW, S_FIN
    } mbp_state_t;

    typedef struct packed {
        logic en;
        logic clr;
    } mbp_mac_ctl_t;

    // piecewise-linear sigmoid, result in Q1.FRACTION_BITS (0..ONE)
    function automatic logic [ACT_BITS-1:0] sigmoid(input logic signed [NET_BITS-1:0] x);
        logic [NET_BITS-1:0] a;
        logic [ACT_BITS-1:0] y;
        a = x[NET_BITS-1] ? NET_BITS'(-x) : NET_BITS'(x);
        if (a >= NET_BITS'(SIG_SAT))
            y = ACT_BITS'(ONE_VAL);
        else if (a >= NET_BITS'(SIG_KNEE2))
            y = ACT_BITS'(a >> 5) + ACT_BITS'(SIG_OFS2);
        else if (a >= NET_BITS'(ONE_VAL))
            y = ACT_BITS'(a >> 3) + ACT_BITS'(SIG_OFS1);
        else
            y = ACT_BITS'(a >> 2) + ACT_BITS'(SIG_OFS0);
        return x[NET_BITS-1] ? ACT_BITS'(ONE_VAL) - y : y;
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic logic signed [ACC_BITS-1:0] rnd(input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] t;
        t = v + ACC_BITS'(ONE_VAL / 2);
        return t >>> FRACTION_BITS;
    endfunction

    function automatic logic signed [WEIGHT_BITS-1:0] sat_w(
        input logic signed [UPD_BITS-1:0] v);
        logic signed [UPD_BITS-1:0] hi;
        logic signed [UPD_BITS-1:0] lo;
        hi = UPD_BITS'((1 << (WEIGHT_BITS - 1)) - 1);
        lo = -UPD_BITS'(1 << (WEIGHT_BITS - 1));
        if (v > hi)
            return WEIGHT_BITS'(hi);
        else if (v < lo)
            return WEIGHT_BITS'(lo);
        return WEIGHT_BITS'(v);
    endfunction

endpackage

>>> src/mbp_mac.sv
// Shared signed multiply-accumulate unit with registered accumulator.
`timescale 1ns / 1ps
module mbp_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mbp_pkg::mbp_mac_ctl_t                  ctl,
    input  logic signed [mbp_pkg::MA_BITS-1:0]     op_a,
    input  logic signed [mbp_pkg::MB_BITS-1:0]     op_b,
    output logic signed [mbp_pkg::ACC_BITS-1:0]    acc
);

    logic signed [mbp_pkg::MA_BITS+mbp_pkg::MB_BITS-1:0] prod;
    logic signed [mbp_pkg::ACC_BITS-1:0]                 acc_reg;
    logic signed [mbp_pkg::ACC_BITS-1:0]                 acc_next;

    assign prod = op_a * op_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.en)
            acc_next = (ctl.clr ? '0 : acc_reg) + mbp_pkg::ACC_BITS'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

>>> src/mlp_backprop_train_step_unit.sv
// Top level of the 2-4-2 perceptron training unit: sequencer, weights, datapath.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive command and its fields with start high; the command
//   transfers at a rising edge where start is high and busy is low. busy then
//   stays high until the result has been shown.
//   Result channel: done is high for exactly one cycle with out_a/out_b valid;
//   the receiver cannot stall it, so sample it in that cycle. Load and the
//   unused command return zeros.
//   Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
//   high. Index 0 is the learning rate (Q1.12), 1 the threshold (Q4.12).
//   Write only while busy is low.
// Timing: set by the one shared MAC unit and its sequencer. One command at a
//   time: a new command is taken only after the last one has finished.
// Reset: rst_n is asynchronous, active low; all weights clear to zero, the
//   learning rate returns to 0.8 and the threshold to zero.
module mlp_backprop_train_step_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic [3:0]                        weight_index,
    input  logic signed [15:0]                weight_value,
    input  logic                              in_a,
    input  logic                              in_b,
    input  logic                              target_a,
    input  logic                              target_b,
    output logic                              done,
    output logic [12:0]                       out_a,
    output logic [12:0]                       out_b,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);

    localparam int WB  = mbp_pkg::WEIGHT_BITS;
    localparam int HB  = mbp_pkg::HID_IDX_BITS;
    localparam int KB  = mbp_pkg::OUT_IDX_BITS;
    localparam int AB  = mbp_pkg::ACT_BITS;
    localparam int EB  = mbp_pkg::ERR_BITS;
    localparam int NB  = mbp_pkg::NET_BITS;
    localparam int MA  = mbp_pkg::MA_BITS;
    localparam int MB  = mbp_pkg::MB_BITS;
    localparam int CB  = mbp_pkg::ACC_BITS;
    localparam int SB  = mbp_pkg::SLOPE_BITS;
    localparam int UB  = mbp_pkg::UPD_BITS;
    localparam int FB  = mbp_pkg::FRACTION_BITS;

    // Sequencer state and loop counters
    mbp_pkg::mbp_state_t state_reg, state_next;
    logic [HB-1:0]       n_reg, n_next;
    logic [KB-1:0]       k_reg, k_next;

    // Latched command
    mbp_pkg::mbp_cmd_t   cmd_reg;
    logic [3:0]          idx_reg;
    logic signed [WB-1:0] val_reg;
    logic                x0_reg, x1_reg, t0_reg, t1_reg;

    // Configuration
    logic [mbp_pkg::LR_BITS-1:0]         lr_reg;
    logic signed [mbp_pkg::THR_BITS-1:0] thr_reg;

    // Weights: hidden ones split by input so each array is read at one address
    logic signed [WB-1:0] hw0_reg [mbp_pkg::HIDDEN_COUNT];
    logic signed [WB-1:0] hw1_reg [mbp_pkg::HIDDEN_COUNT];
    logic signed [WB-1:0] ow_reg  [mbp_pkg::HIDDEN_COUNT * mbp_pkg::OUTPUT_COUNT];

    // Per-sample working values
    logic [AB-1:0]                 h_reg  [mbp_pkg::HIDDEN_COUNT];
    logic [AB-1:0]                 o_reg  [mbp_pkg::OUTPUT_COUNT];
    logic signed [mbp_pkg::EH_BITS-1:0] eh_reg [mbp_pkg::HIDDEN_COUNT];
    logic [SB-1:0]                 d_reg;
    logic signed [MA-1:0]          u_reg;

    // MAC unit connection
    mbp_pkg::mbp_mac_ctl_t mac_ctl;
    logic signed [MA-1:0]  mac_a;
    logic signed [MB-1:0]  mac_b;
    logic signed [CB-1:0]  acc;
    logic signed [CB-1:0]  acc_rnd;

    logic                  accept;
    logic                  last_n, last_k;
    logic [HB+KB-1:0]      ow_sel;
    logic signed [EB-1:0]  eo_k;
    logic signed [NB-1:0]  hid_net;
    logic signed [NB-1:0]  out_net;
    logic signed [UB-1:0]  upd;
    logic                  tg_k;

    assign accept    = start && !busy;
    assign busy      = (state_reg != mbp_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign last_n    = (n_reg == HB'(mbp_pkg::HIDDEN_COUNT - 1));
    assign last_k    = (k_reg == KB'(mbp_pkg::OUTPUT_COUNT - 1));
    assign ow_sel    = {k_reg, n_reg};
    assign acc_rnd   = mbp_pkg::rnd(acc);
    assign upd       = UB'(acc_rnd);

    // Output error of output k: target*ONE - o
    assign tg_k = (k_reg == '0) ? t0_reg : t1_reg;
    assign eo_k = (tg_k ? EB'(mbp_pkg::ONE_VAL) : EB'(0)) - EB'(o_reg[k_reg]);

    // Hidden net: sum of active-input weights minus threshold
    assign hid_net = (x0_reg ? NB'(hw0_reg[n_reg]) : NB'(0))
                   + (x1_reg ? NB'(hw1_reg[n_reg]) : NB'(0))
                   - NB'(thr_reg);
    assign out_net = NB'(acc_rnd) - NB'(thr_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        unique case (state_reg)
            mbp_pkg::S_IDLE:
            begin
                n_next = '0;
                k_next = '0;
                if (accept)
                begin
                    unique case (mbp_pkg::mbp_cmd_t'(command))
                        mbp_pkg::CMD_LOAD:  state_next = mbp_pkg::S_LOAD;
                        mbp_pkg::CMD_INFER,
                        mbp_pkg::CMD_TRAIN: state_next = mbp_pkg::S_HID;
                        default:            state_next = mbp_pkg::S_FIN;
                    endcase
                end
            end
            mbp_pkg::S_LOAD: state_next = mbp_pkg::S_FIN;
            mbp_pkg::S_HID:
            begin
                n_next = n_reg + 1'b1;
                if (last_n)
                    state_next = mbp_pkg::S_OMAC;
            end
            mbp_pkg::S_OMAC:
            begin
                n_next = n_reg + 1'b1;
                if (last_n)
                    state_next = mbp_pkg::S_OSIG;
            end
            mbp_pkg::S_OSIG:
            begin
                k_next = k_reg + 1'b1;
                if (!last_k)
                    state_next = mbp_pkg::S_OMAC;
                else if (cmd_reg == mbp_pkg::CMD_TRAIN)
                    state_next = mbp_pkg::S_EMAC;
                else
                    state_next = mbp_pkg::S_FIN;
            end
            mbp_pkg::S_EMAC:
            begin
                k_next = k_reg + 1'b1;
                if (last_k)
                    state_next = mbp_pkg::S_EH;
            end
            mbp_pkg::S_EH:
            begin
                n_next     = n_reg + 1'b1;
                state_next = last_n ? mbp_pkg::S_HD : mbp_pkg::S_EMAC;
            end
            mbp_pkg::S_HD: state_next = mbp_pkg::S_HL;
            mbp_pkg::S_HL: state_next = mbp_pkg::S_HT;
            mbp_pkg::S_HT: state_next = mbp_pkg::S_HW;
            mbp_pkg::S_HW:
            begin
                n_next     = n_reg + 1'b1;
                state_next = last_n ? mbp_pkg::S_OD : mbp_pkg::S_HD;
            end
            mbp_pkg::S_OD: state_next = mbp_pkg::S_OL;
            mbp_pkg::S_OL: state_next = mbp_pkg::S_OT;
            mbp_pkg::S_OT: state_next = mbp_pkg::S_OU;
            mbp_pkg::S_OU: state_next = mbp_pkg::S_ON;
            mbp_pkg::S_ON: state_next = mbp_pkg::S_OW;
            mbp_pkg::S_OW:
            begin
                n_next = n_reg + 1'b1;
                if (!last_n)
                    state_next = mbp_pkg::S_ON;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = last_k ? mbp_pkg::S_FIN : mbp_pkg::S_OD;
                end
            end
            mbp_pkg::S_FIN: state_next = mbp_pkg::S_IDLE;
            default:        state_next = mbp_pkg::S_IDLE;
        endcase
    end

    // MAC operand selection per step
    always_comb
    begin
        mac_ctl = '{en: 1'b0, clr: 1'b1};
        mac_a   = '0;
        mac_b   = '0;
        unique case (state_reg)
            mbp_pkg::S_OMAC:
            begin
                mac_ctl = '{en: 1'b1, clr: (n_reg == '0)};
                mac_a   = MA'(ow_reg[ow_sel]);
                mac_b   = MB'({1'b0, h_reg[n_reg]});
            end
            mbp_pkg::S_EMAC:
            begin
                mac_ctl = '{en: 1'b1, clr: (k_reg == '0)};
                mac_a   = MA'(ow_reg[ow_sel]);
                mac_b   = MB'(eo_k);
            end
            mbp_pkg::S_HD:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b1};
                mac_a   = MA'({1'b0, h_reg[n_reg]});
                mac_b   = MB'(AB'(mbp_pkg::ONE_VAL) - h_reg[n_reg]);
            end
            mbp_pkg::S_HL:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b1};
                mac_a   = MA'({1'b0, lr_reg});
                mac_b   = MB'(eh_reg[n_reg]);
            end
            mbp_pkg::S_HT,
            mbp_pkg::S_OT:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b1};
                mac_a   = MA'(acc_rnd);
                mac_b   = MB'({1'b0, d_reg});
            end
            mbp_pkg::S_OD:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b1};
                mac_a   = MA'({1'b0, o_reg[k_reg]});
                mac_b   = MB'(AB'(mbp_pkg::ONE_VAL) - o_reg[k_reg]);
            end
            mbp_pkg::S_OL:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b1};
                mac_a   = MA'({1'b0, lr_reg});
                mac_b   = MB'(eo_k);
            end
            mbp_pkg::S_ON:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b1};
                mac_a   = u_reg;
                mac_b   = MB'({1'b0, h_reg[n_reg]});
            end
            default:
            begin
                mac_ctl = '{en: 1'b0, clr: 1'b1};
            end
        endcase
    end

    mbp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (acc)
    );

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbp_pkg::S_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
            cmd_reg   <= mbp_pkg::CMD_NOP;
            lr_reg    <= mbp_pkg::LR_BITS'(mbp_pkg::LR_RESET);
            thr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            if (accept)
                cmd_reg <= mbp_pkg::mbp_cmd_t'(command);
            if (cfg_valid && cfg_ready)
            begin
                unique case (mbp_pkg::mbp_reg_t'(cfg_index))
                    mbp_pkg::REG_LEARNING_RATE: lr_reg  <= cfg_data[mbp_pkg::LR_BITS-1:0];
                    mbp_pkg::REG_THRESHOLD:     thr_reg <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    // Weight store: clear at reset, load and update from the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mbp_pkg::HIDDEN_COUNT; i++)
            begin
                hw0_reg[i] <= '0;
                hw1_reg[i] <= '0;
            end
            for (int i = 0; i < mbp_pkg::HIDDEN_COUNT * mbp_pkg::OUTPUT_COUNT; i++)
                ow_reg[i] <= '0;
        end
        else
        begin
            if (state_reg == mbp_pkg::S_LOAD)
            begin
                if (idx_reg < 4'(mbp_pkg::HW_COUNT))
                begin
                    if (idx_reg[0])
                        hw1_reg[idx_reg[HB:1]] <= val_reg;
                    else
                        hw0_reg[idx_reg[HB:1]] <= val_reg;
                end
                else
                    ow_reg[idx_reg[HB+KB-1:0]] <= val_reg;
            end
            if (state_reg == mbp_pkg::S_HW)
            begin
                if (x0_reg)
                    hw0_reg[n_reg] <= mbp_pkg::sat_w(UB'(hw0_reg[n_reg]) + upd);
                if (x1_reg)
                    hw1_reg[n_reg] <= mbp_pkg::sat_w(UB'(hw1_reg[n_reg]) + upd);
            end
            if (state_reg == mbp_pkg::S_OW)
                ow_reg[ow_sel] <= mbp_pkg::sat_w(UB'(ow_reg[ow_sel]) + upd);
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= weight_index;
            val_reg <= weight_value;
            x0_reg  <= in_a;
            x1_reg  <= in_b;
            t0_reg  <= target_a;
            t1_reg  <= target_b;
        end
        if (state_reg == mbp_pkg::S_HID)
            h_reg[n_reg] <= mbp_pkg::sigmoid(hid_net);
        if (state_reg == mbp_pkg::S_OSIG)
            o_reg[k_reg] <= mbp_pkg::sigmoid(out_net);
        if (state_reg == mbp_pkg::S_EH)
            eh_reg[n_reg] <= mbp_pkg::EH_BITS'(acc_rnd);
        if (state_reg == mbp_pkg::S_HL || state_reg == mbp_pkg::S_OL)
            d_reg <= acc[FB+SB-1:FB];
        if (state_reg == mbp_pkg::S_OU)
            u_reg <= MA'(acc_rnd);
    end

    // Result: zero unless the command ran the forward pass
    assign done  = (state_reg == mbp_pkg::S_FIN);
    assign out_a = (cmd_reg == mbp_pkg::CMD_INFER || cmd_reg == mbp_pkg::CMD_TRAIN)
                   ? o_reg[0] : '0;
    assign out_b = (cmd_reg == mbp_pkg::CMD_INFER || cmd_reg == mbp_pkg::CMD_TRAIN)
                   ? o_reg[1] : '0;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted command did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe not followed by idle");

    a_load_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbp_pkg::S_LOAD) |=> done)
        else $error("load did not finish in the next cycle");

    a_train_only_updates: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbp_pkg::S_HW || state_reg == mbp_pkg::S_OW)
        |-> cmd_reg == mbp_pkg::CMD_TRAIN)
        else $error("weight update outside a train command");
`endif

endmodule
